### design/hfrg_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the Haar feature rectangle generator.
// No dependencies; imported by hfrg_pipe and haar_feature_rectangle_generator_core.
package hfrg_pkg;

    // Largest accepted feature side before flip.
    localparam int MAX_SIDE = 64;

    // Rectangles per feature at most.
    localparam int NUM_RECT = 4;

    // Template types.
    localparam logic [3:0] FT_FULL    = 4'd0;
    localparam logic [3:0] FT_DIAG_A  = 4'd1;
    localparam logic [3:0] FT_DIAG_B  = 4'd2;
    localparam logic [3:0] FT_CHECKER = 4'd3;
    localparam logic [3:0] FT_CENTER  = 4'd4;
    localparam logic [3:0] FT_EDGE2   = 4'd5;
    localparam logic [3:0] FT_LINE3_C = 4'd6;
    localparam logic [3:0] FT_LINE3_S = 4'd7;
    localparam logic [3:0] FT_LINE4_C = 4'd8;
    localparam logic [3:0] FT_LINE4_S = 4'd9;
    localparam logic [3:0] FT_CROSS_A = 4'd10;
    localparam logic [3:0] FT_CROSS_B = 4'd11;

    // Configuration register indexes.
    localparam logic CFG_IMG_W = 1'b0;
    localparam logic CFG_IMG_H = 1'b1;

    localparam logic [6:0] IMG_W_RST = 7'd24;
    localparam logic [6:0] IMG_H_RST = 7'd24;

    // Rectangle weights.
    localparam logic signed [2:0] WT_ZERO = 3'sb000;
    localparam logic signed [2:0] WT_P1   = 3'sb001;
    localparam logic signed [2:0] WT_N1   = 3'sb111;
    localparam logic signed [2:0] WT_N2   = 3'sb110;
    localparam logic signed [2:0] WT_N3   = 3'sb101;
    localparam logic signed [2:0] WT_N4   = 3'sb100;

    typedef struct packed {
        logic signed [7:0] l;
        logic signed [7:0] r;
        logic signed [7:0] t;
        logic signed [7:0] b;
        logic signed [2:0] w;
    } t_rect;

    typedef struct packed {
        t_rect [NUM_RECT-1:0] rects;
        logic [1:0]           last_idx;
        logic                 valid;
        logic                 bad;
    } t_feat;

    function automatic logic [2:0] min_w(input logic [3:0] ft);
        logic [2:0] m;
        case (ft)
            FT_DIAG_A, FT_DIAG_B, FT_CHECKER: m = 3'd2;
            FT_CENTER, FT_CROSS_A, FT_CROSS_B: m = 3'd3;
            default: m = 3'd1;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] min_h(input logic [3:0] ft);
        logic [2:0] m;
        case (ft)
            FT_DIAG_A, FT_DIAG_B, FT_CHECKER, FT_EDGE2: m = 3'd2;
            FT_CENTER, FT_LINE3_C, FT_LINE3_S, FT_CROSS_A, FT_CROSS_B: m = 3'd3;
            FT_LINE4_C, FT_LINE4_S: m = 3'd4;
            default: m = 3'd1;
        endcase
        return m;
    endfunction

    // Floor of x / 3 through the reciprocal 171 / 512, exact for x below 512.
    function automatic logic [6:0] div3(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd171;
        return p[15:9];
    endfunction

    function automatic logic signed [7:0] at(input logic [6:0] x);
        return $signed({1'b0, x});
    endfunction

    function automatic logic signed [7:0] am1(input logic [6:0] x);
        return $signed({1'b0, x}) - 8'sd1;
    endfunction

    function automatic t_rect mkr(input logic signed [7:0] l, input logic signed [7:0] r,
                                  input logic signed [7:0] t, input logic signed [7:0] b,
                                  input logic signed [2:0] w);
        t_rect x;
        x.l = l;
        x.r = r;
        x.t = t;
        x.b = b;
        x.w = w;
        return x;
    endfunction

    // Coordinates never go below -1; only the top end needs clamping.
    function automatic logic signed [7:0] sat(input logic signed [8:0] v);
        return (v > 9'sd127) ? 8'sd127 : v[7:0];
    endfunction

endpackage

### design/hfrg_pipe.sv
`timescale 1ns / 1ps
// Three-stage geometry pipeline: request decode and fractions, template build,
// then flip, placement and validity. Depends on hfrg_pkg.
module hfrg_pipe
    import hfrg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_type,
    input  logic [6:0] i_fw,
    input  logic [6:0] i_fh,
    input  logic [5:0] i_top,
    input  logic [5:0] i_left,
    input  logic       i_flip,
    input  logic [6:0] i_img_w,
    input  logic [6:0] i_img_h,
    output logic       o_valid,
    input  logic       i_ready,
    output t_feat      o_feat
);

    logic en1, en2, en3;

    // Stage 1 registers.
    logic       r_v1;
    logic [3:0] r_type;
    logic [6:0] r_fw, r_fh;
    logic [5:0] r_top, r_left;
    logic       r_flip, r_bad;
    logic [6:0] r_w2, r_h2, r_w3a, r_w3b, r_h3a, r_h3b, r_w4a, r_w4b;
    logic [6:0] r_cl, r_cr, r_ct, r_cb;

    // Stage 2 registers.
    logic                 r_v2;
    t_rect [NUM_RECT-1:0] r_rects;
    logic [1:0]           r_last;
    logic [6:0]           r_fw2, r_fh2;
    logic [5:0]           r_top2, r_left2;
    logic                 r_flip2, r_bad2;

    // Stage 3 registers.
    logic  r_v3;
    t_feat r_feat;

    logic                 n_bad;
    logic [6:0]           n_w2, n_h2, n_w4b;
    logic [7:0]           n_ws, n_hs;
    t_rect [NUM_RECT-1:0] n_rects;
    logic [1:0]           n_last;
    t_feat                n_feat;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_feat  = r_feat;

    // Stage 1: reject check and the fractions of the sides.
    always_comb begin
        n_bad = (i_type > FT_CROSS_B) || (i_fw < 7'(min_w(i_type)))
             || (i_fh < 7'(min_h(i_type))) || ({2'b00, i_fw} > 9'(MAX_SIDE))
             || ({2'b00, i_fh} > 9'(MAX_SIDE));
        n_w2  = {1'b0, i_fw[6:1]};
        n_h2  = {1'b0, i_fh[6:1]};
        n_w4b = 7'(({2'b00, i_fw} + {1'b0, i_fw, 1'b0}) >> 2);
        n_ws  = {1'b0, i_fw} + {1'b0, n_w2};
        n_hs  = {1'b0, i_fh} + {1'b0, n_h2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
        if (en1 && i_valid) begin
            r_type <= i_type;
            r_fw   <= i_fw;
            r_fh   <= i_fh;
            r_top  <= i_top;
            r_left <= i_left;
            r_flip <= i_flip;
            r_bad  <= n_bad;
            r_w2   <= n_w2;
            r_h2   <= n_h2;
            r_w3a  <= div3({1'b0, i_fw});
            r_w3b  <= div3({i_fw, 1'b0});
            r_h3a  <= div3({1'b0, i_fh});
            r_h3b  <= div3({i_fh, 1'b0});
            r_w4a  <= {2'b00, i_fw[6:2]};
            r_w4b  <= n_w4b;
            r_cl   <= 7'((i_fw - n_w2) >> 1);
            r_cr   <= n_ws[7:1];
            r_ct   <= 7'((i_fh - n_h2) >> 1);
            r_cb   <= n_hs[7:1];
        end
    end

    // Stage 2: template rectangles in feature space, before flip.
    always_comb begin
        n_rects = '0;
        n_last  = 2'd1;
        case (r_type)
            FT_FULL: begin
                n_rects[0] = mkr(8'sd0, am1(r_fw), 8'sd0, am1(r_fh), WT_P1);
                n_last     = 2'd0;
            end
            FT_DIAG_A: begin
                n_rects[0] = mkr(8'sd0, am1(r_w2), 8'sd0, am1(r_h2), WT_P1);
                n_rects[1] = mkr(at(r_w2), am1(r_fw), at(r_h2), am1(r_fh), WT_N1);
            end
            FT_DIAG_B: begin
                n_rects[0] = mkr(at(r_w2), am1(r_fw), 8'sd0, am1(r_h2), WT_P1);
                n_rects[1] = mkr(8'sd0, am1(r_w2), at(r_h2), am1(r_fh), WT_N1);
            end
            FT_CHECKER: begin
                n_rects[0] = mkr(8'sd0, am1(r_w2), 8'sd0, am1(r_h2), WT_P1);
                n_rects[1] = mkr(at(r_w2), am1(r_fw), 8'sd0, am1(r_h2), WT_N1);
                n_rects[2] = mkr(at(r_w2), am1(r_fw), at(r_h2), am1(r_fh), WT_P1);
                n_rects[3] = mkr(8'sd0, am1(r_w2), at(r_h2), am1(r_fh), WT_N1);
                n_last     = 2'd3;
            end
            FT_CENTER: begin
                n_rects[0] = mkr(8'sd0, am1(r_fw), 8'sd0, am1(r_fh), WT_P1);
                n_rects[1] = mkr(at(r_cl), am1(r_cr), at(r_ct), am1(r_cb), WT_N4);
            end
            FT_EDGE2: begin
                n_rects[0] = mkr(8'sd0, am1(r_w2), 8'sd0, am1(r_fh), WT_P1);
                n_rects[1] = mkr(at(r_w2), am1(r_fw), 8'sd0, am1(r_fh), WT_N1);
            end
            FT_LINE3_C: begin
                n_rects[0] = mkr(8'sd0, am1(r_fw), 8'sd0, am1(r_fh), WT_P1);
                n_rects[1] = mkr(at(r_w3a), am1(r_w3b), 8'sd0, am1(r_fh), WT_N3);
            end
            FT_LINE3_S: begin
                n_rects[0] = mkr(8'sd0, am1(r_w3a), 8'sd0, am1(r_fh), WT_P1);
                n_rects[1] = mkr(at(r_w3b), am1(r_fw), 8'sd0, am1(r_fh), WT_N1);
            end
            FT_LINE4_C: begin
                n_rects[0] = mkr(8'sd0, am1(r_fw), 8'sd0, am1(r_fh), WT_P1);
                n_rects[1] = mkr(at(r_w4a), am1(r_w4b), 8'sd0, am1(r_fh), WT_N2);
            end
            FT_LINE4_S: begin
                n_rects[0] = mkr(8'sd0, am1(r_w4a), 8'sd0, am1(r_fh), WT_P1);
                n_rects[1] = mkr(at(r_w4b), am1(r_fw), 8'sd0, am1(r_fh), WT_N1);
            end
            FT_CROSS_A: begin
                n_rects[0] = mkr(8'sd0, am1(r_w3a), at(r_h3a), am1(r_h3b), WT_P1);
                n_rects[1] = mkr(at(r_w3a), am1(r_w3b), at(r_h3b), am1(r_fh), WT_N1);
                n_rects[2] = mkr(at(r_w3a), am1(r_w3b), 8'sd0, am1(r_h3a), WT_P1);
                n_rects[3] = mkr(at(r_w3b), am1(r_fw), at(r_h3a), am1(r_h3b), WT_N1);
                n_last     = 2'd3;
            end
            default: begin
                n_rects[0] = mkr(at(r_w3a), am1(r_w3b), 8'sd0, am1(r_h3a), WT_P1);
                n_rects[1] = mkr(8'sd0, am1(r_w3a), at(r_h3a), am1(r_h3b), WT_N1);
                n_rects[2] = mkr(at(r_w3b), am1(r_fw), at(r_h3a), am1(r_h3b), WT_P1);
                n_rects[3] = mkr(at(r_w3a), am1(r_w3b), at(r_h3b), am1(r_fh), WT_N1);
                n_last     = 2'd3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2 && r_v1) begin
            r_rects <= n_rects;
            r_last  <= n_last;
            r_fw2   <= r_fw;
            r_fh2   <= r_fh;
            r_top2  <= r_top;
            r_left2 <= r_left;
            r_flip2 <= r_flip;
            r_bad2  <= r_bad;
        end
    end

    // Stage 3: flip, move to the requested corner and judge validity.
    // Every template touches row 0 and column 0 and spans the full width and
    // height, so the bounding box is the feature itself.
    always_comb begin
        logic              box_ok;
        logic              all_ne;
        logic signed [7:0] cl, cr, ct, cb;
        logic signed [8:0] ox, oy;
        n_feat          = '0;
        n_feat.last_idx = r_last;
        ox     = $signed({3'b000, r_left2});
        oy     = $signed({3'b000, r_top2});
        box_ok = ((8'(r_left2) + 8'(r_flip2 ? r_fh2 : r_fw2)) <= 8'(i_img_w))
              && ((8'(r_top2) + 8'(r_flip2 ? r_fw2 : r_fh2)) <= 8'(i_img_h));
        all_ne = 1'b1;
        for (int i = 0; i < NUM_RECT; i++) begin
            cl = r_flip2 ? r_rects[i].t : r_rects[i].l;
            cr = r_flip2 ? r_rects[i].b : r_rects[i].r;
            ct = r_flip2 ? r_rects[i].l : r_rects[i].t;
            cb = r_flip2 ? r_rects[i].r : r_rects[i].b;
            if ((2'(i) <= r_last) && ((cl > cr) || (ct > cb))) begin
                all_ne = 1'b0;
            end
            n_feat.rects[i].l = sat(ox + {cl[7], cl});
            n_feat.rects[i].r = sat(ox + {cr[7], cr});
            n_feat.rects[i].t = sat(oy + {ct[7], ct});
            n_feat.rects[i].b = sat(oy + {cb[7], cb});
            n_feat.rects[i].w = r_rects[i].w;
        end
        n_feat.valid = box_ok && all_ne;
        if (r_bad2) begin
            n_feat            = '0;
            n_feat.bad        = 1'b1;
            n_feat.rects[0].w = WT_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
        if (en3 && r_v2) begin
            r_feat <= n_feat;
        end
    end

endmodule

### design/haar_feature_rectangle_generator_core.sv
`timescale 1ns / 1ps
// Top level of the Haar feature rectangle generator: stream ports, configuration
// registers and the rectangle output register. Depends on hfrg_pkg and hfrg_pipe.
//
// A request beat enters a three-stage pipeline (decode, template build, placement)
// and comes out as one, two or four rectangle beats, the last one marked by tlast.
// The output register sends one rectangle beat per cycle while the sink is ready, so
// a request occupies the output for one beat per rectangle: one for a rejected request
// or the full-box template, two for most templates, four for the checker and cross
// templates. Requests are taken every cycle while the pipeline has room; the first
// rectangle reaches the output after its request has passed the stage 1, 2 and 3
// registers and the output register. Image size writes on the configuration port
// take effect on requests placed after them.
module haar_feature_rectangle_generator_core
    import hfrg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] feature_type, [10:4] feature_width, [17:11] feature_height,
    // [23:18] pos_top, [29:24] pos_left, [30] flip_diag, [31] zero.
    input  logic [31:0] s_axis_tdata,
    // Rectangle stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] rect_left, [15:8] rect_right, [23:16] rect_top, [31:24] rect_bottom,
    // [34:32] rect_weight, [39:35] zero.
    output logic [39:0] m_axis_tdata,
    // [0] feature_valid, [1] bad_request.
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);

    logic [6:0] r_img_w, r_img_h;
    logic       pipe_valid, pipe_take;
    t_feat      pipe_feat;

    logic       r_ov;
    t_feat      r_q;
    logic [1:0] r_cnt;
    logic       beat, last;
    t_rect      cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_W_RST;
            r_img_h <= IMG_H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IMG_W: r_img_w <= i_cfg_wdata;
                CFG_IMG_H: r_img_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    hfrg_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_type  (s_axis_tdata[3:0]),
        .i_fw    (s_axis_tdata[10:4]),
        .i_fh    (s_axis_tdata[17:11]),
        .i_top   (s_axis_tdata[23:18]),
        .i_left  (s_axis_tdata[29:24]),
        .i_flip  (s_axis_tdata[30]),
        .i_img_w (r_img_w),
        .i_img_h (r_img_h),
        .o_valid (pipe_valid),
        .i_ready (pipe_take),
        .o_feat  (pipe_feat)
    );

    assign beat = r_ov && m_axis_tready;
    assign last = (r_cnt == r_q.last_idx);
    // Loads a new feature when the output is empty or the last rectangle leaves.
    assign pipe_take = !r_ov || (beat && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_cnt <= 2'd0;
        end else if (pipe_take) begin
            r_ov  <= pipe_valid;
            r_cnt <= 2'd0;
        end else if (beat) begin
            r_cnt <= r_cnt + 2'd1;
        end
        if (pipe_take && pipe_valid) begin
            r_q <= pipe_feat;
        end
    end

    assign cur           = r_q.rects[r_cnt];
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'b00000, cur.w, cur.b, cur.t, cur.r, cur.l};
    assign m_axis_tuser  = {r_q.bad, r_q.valid};
    assign m_axis_tlast  = last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_cnt <= r_q.last_idx))
        else $error("rectangle index beyond feature end");

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_q.bad) |-> ((r_q.last_idx == 2'd0) && !r_q.valid))
        else $error("rejected request not a single invalid beat");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && !last) |=> (r_ov && (r_cnt == $past(r_cnt) + 2'd1)))
        else $error("rectangle sequence did not advance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_cnt)))
        else $error("output state changed during stall");

endmodule

### dv/haar_feature_rectangle_generator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for haar_feature_rectangle_generator_core: drives feature
// requests, predicts every rectangle beat and compares them. Needs hfrg_pkg and the core.
module haar_feature_rectangle_generator_core_tb;
    import hfrg_pkg::*;

    typedef struct packed {
        logic [3:0] ftype;
        logic [6:0] fw;
        logic [6:0] fh;
        logic [5:0] top;
        logic [5:0] left;
        logic       flip;
    } req_t;

    typedef struct {
        logic [7:0] l;
        logic [7:0] r;
        logic [7:0] t;
        logic [7:0] b;
        logic [2:0] w;
        logic       fv;
        logic       bad;
        logic       last;
    } rect_beat_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;

    haar_feature_rectangle_generator_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Smallest legal width and height per template; unknown types never index these.
    int min_fw_tab[16] = '{1, 2, 2, 2, 3, 1, 1, 1, 1, 1, 3, 3, 0, 0, 0, 0};
    int min_fh_tab[16] = '{1, 2, 2, 2, 3, 2, 3, 3, 4, 4, 3, 3, 0, 0, 0, 0};

    int img_w = int'(IMG_W_RST);
    int img_h = int'(IMG_H_RST);

    int box_l[4], box_r[4], box_t[4], box_b[4], box_w[4];

    rect_beat_t pending_rects[$];
    int  fail_count = 0;
    int  n_requests = 0;
    int  n_rects = 0;
    int  n_cfg = 0;
    bit  src_idle_en = 1'b1;
    bit  snk_idle_en = 1'b1;
    bit  req_offered = 1'b0;
    int  sink_hold_cycles = 0;
    int  sink_wait = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL haar_feature_rectangle_generator_core");
        $finish;
    end

    function automatic void put_box(input int i, input int l, input int r, input int t,
                                    input int b, input int w);
        box_l[i] = l;
        box_r[i] = r;
        box_t[i] = t;
        box_b[i] = b;
        box_w[i] = w;
    endfunction

    // Queues one bad beat for a rejected request; else builds the template, flips it,
    // moves it to the requested corner and queues one expected beat per rectangle.
    function automatic void predict_rects(input req_t rq);
        int fw, fh, n, dx, dy, ul, ur, ut, ub, sw, v;
        int w2, h2, w3a, w3b, h3a, h3b, w4a, w4b;
        bit fits;
        rect_beat_t e;
        fw = int'(rq.fw);
        fh = int'(rq.fh);
        if (rq.ftype > FT_CROSS_B || fw < min_fw_tab[rq.ftype] || fh < min_fh_tab[rq.ftype]
                || fw > MAX_SIDE || fh > MAX_SIDE) begin
            e = '{default: '0};
            e.bad = 1'b1;
            e.last = 1'b1;
            pending_rects = {pending_rects, e};
            return;
        end
        w2 = fw / 2;
        h2 = fh / 2;
        w3a = fw / 3;
        w3b = (fw * 2) / 3;
        h3a = fh / 3;
        h3b = (fh * 2) / 3;
        w4a = fw / 4;
        w4b = (fw * 3) / 4;
        n = 2;
        case (rq.ftype)
            FT_FULL: begin
                put_box(0, 0, fw - 1, 0, fh - 1, 1);
                n = 1;
            end
            FT_DIAG_A: begin
                put_box(0, 0, w2 - 1, 0, h2 - 1, 1);
                put_box(1, w2, fw - 1, h2, fh - 1, -1);
            end
            FT_DIAG_B: begin
                put_box(0, w2, fw - 1, 0, h2 - 1, 1);
                put_box(1, 0, w2 - 1, h2, fh - 1, -1);
            end
            FT_CHECKER: begin
                put_box(0, 0, w2 - 1, 0, h2 - 1, 1);
                put_box(1, w2, fw - 1, 0, h2 - 1, -1);
                put_box(2, w2, fw - 1, h2, fh - 1, 1);
                put_box(3, 0, w2 - 1, h2, fh - 1, -1);
                n = 4;
            end
            FT_CENTER: begin
                put_box(0, 0, fw - 1, 0, fh - 1, 1);
                put_box(1, (fw - w2) / 2, (fw + w2) / 2 - 1,
                        (fh - h2) / 2, (fh + h2) / 2 - 1, -4);
            end
            FT_EDGE2: begin
                put_box(0, 0, w2 - 1, 0, fh - 1, 1);
                put_box(1, w2, fw - 1, 0, fh - 1, -1);
            end
            FT_LINE3_C: begin
                put_box(0, 0, fw - 1, 0, fh - 1, 1);
                put_box(1, w3a, w3b - 1, 0, fh - 1, -3);
            end
            FT_LINE3_S: begin
                put_box(0, 0, w3a - 1, 0, fh - 1, 1);
                put_box(1, w3b, fw - 1, 0, fh - 1, -1);
            end
            FT_LINE4_C: begin
                put_box(0, 0, fw - 1, 0, fh - 1, 1);
                put_box(1, w4a, w4b - 1, 0, fh - 1, -2);
            end
            FT_LINE4_S: begin
                put_box(0, 0, w4a - 1, 0, fh - 1, 1);
                put_box(1, w4b, fw - 1, 0, fh - 1, -1);
            end
            FT_CROSS_A: begin
                put_box(0, 0, w3a - 1, h3a, h3b - 1, 1);
                put_box(1, w3a, w3b - 1, h3b, fh - 1, -1);
                put_box(2, w3a, w3b - 1, 0, h3a - 1, 1);
                put_box(3, w3b, fw - 1, h3a, h3b - 1, -1);
                n = 4;
            end
            default: begin
                put_box(0, w3a, w3b - 1, 0, h3a - 1, 1);
                put_box(1, 0, w3a - 1, h3a, h3b - 1, -1);
                put_box(2, w3b, fw - 1, h3a, h3b - 1, 1);
                put_box(3, w3a, w3b - 1, h3b, fh - 1, -1);
                n = 4;
            end
        endcase
        if (rq.flip) begin
            for (int i = 0; i < n; i++) begin
                sw = box_l[i]; box_l[i] = box_t[i]; box_t[i] = sw;
                sw = box_r[i]; box_r[i] = box_b[i]; box_b[i] = sw;
            end
        end
        ul = box_l[0]; ur = box_r[0]; ut = box_t[0]; ub = box_b[0];
        for (int i = 1; i < n; i++) begin
            if (box_l[i] < ul) ul = box_l[i];
            if (box_r[i] > ur) ur = box_r[i];
            if (box_t[i] < ut) ut = box_t[i];
            if (box_b[i] > ub) ub = box_b[i];
        end
        dx = int'(rq.left) - ul;
        dy = int'(rq.top) - ut;
        fits = (ur + dx) < img_w && (ub + dy) < img_h;
        for (int i = 0; i < n; i++) begin
            box_l[i] += dx; box_r[i] += dx;
            box_t[i] += dy; box_b[i] += dy;
            if (box_l[i] > box_r[i] || box_t[i] > box_b[i]) fits = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            // Validity is judged on full values; the output clamps at the top end.
            v = (box_l[i] > 127) ? 127 : box_l[i]; e.l = 8'(v);
            v = (box_r[i] > 127) ? 127 : box_r[i]; e.r = 8'(v);
            v = (box_t[i] > 127) ? 127 : box_t[i]; e.t = 8'(v);
            v = (box_b[i] > 127) ? 127 : box_b[i]; e.b = 8'(v);
            e.w = 3'(box_w[i]);
            e.fv = fits;
            e.bad = 1'b0;
            e.last = (i == n - 1);
            pending_rects = {pending_rects, e};
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Rectangle sink: checks every beat and draws the stall before the next one.
    always @(posedge i_clk) begin : rect_sink
        rect_beat_t e;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_rects++;
                if (pending_rects.size() == 0) begin
                    $error("rectangle beat with no request outstanding: tdata %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    e = pending_rects.pop_front();
                    check_field("rect_left", $signed(e.l), $signed(m_axis_tdata[7:0]));
                    check_field("rect_right", $signed(e.r), $signed(m_axis_tdata[15:8]));
                    check_field("rect_top", $signed(e.t), $signed(m_axis_tdata[23:16]));
                    check_field("rect_bottom", $signed(e.b), $signed(m_axis_tdata[31:24]));
                    check_field("rect_weight", $signed(e.w), $signed(m_axis_tdata[34:32]));
                    check_field("feature_valid", e.fv, m_axis_tuser[0]);
                    check_field("bad_request", e.bad, m_axis_tuser[1]);
                    check_field("last_rect", e.last, m_axis_tlast);
                end
                sink_wait = snk_idle_en ? $urandom_range(0, 6) : 0;
            end
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one request and returns at the edge where it is taken. Valid stays up
    // so that a following request with no gap goes out back to back.
    task automatic send_req(input logic [3:0] ft, input logic [6:0] fw, input logic [6:0] fh,
                            input logic [5:0] top, input logic [5:0] left, input logic flip);
        req_t rq;
        int gap;
        rq = '{ftype: ft, fw: fw, fh: fh, top: top, left: left, flip: flip};
        gap = src_idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            if (req_offered) s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, rq.flip, rq.left, rq.top, rq.fh, rq.fw, rq.ftype};
        req_offered = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_rects(rq);
        n_requests++;
    endtask

    // Mostly well-formed requests of small size near the origin; the rest is noise.
    task automatic send_random_req();
        logic [3:0] ft;
        int fw, fh, top, left;
        if ($urandom_range(0, 99) < 88) begin
            ft = 4'($urandom_range(0, 11));
            fw = ($urandom_range(0, 3) == 0) ? $urandom_range(min_fw_tab[ft], MAX_SIDE)
                                             : $urandom_range(min_fw_tab[ft], 16);
            fh = ($urandom_range(0, 3) == 0) ? $urandom_range(min_fh_tab[ft], MAX_SIDE)
                                             : $urandom_range(min_fh_tab[ft], 16);
        end else begin
            ft = 4'($urandom_range(0, 15));
            fw = $urandom_range(0, 127);
            fh = $urandom_range(0, 127);
        end
        top = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 12);
        left = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 12);
        send_req(ft, 7'(fw), 7'(fh), 6'(top), 6'(left), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_for_rects();
        if (req_offered) begin
            s_axis_tvalid <= 1'b0;
            req_offered = 1'b0;
        end
        while (pending_rects.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_image_size(input int w, input int h);
        wait_for_rects();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_IMG_W;
        i_cfg_wdata <= 7'(w);
        @(posedge i_clk);
        i_cfg_addr <= CFG_IMG_H;
        i_cfg_wdata <= 7'(h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        img_w = w;
        img_h = h;
        n_cfg++;
    endtask

    task automatic test_templates();
        for (int ft = 0; ft <= int'(FT_CROSS_B); ft++)
            send_req(4'(ft), 7'(min_fw_tab[ft]), 7'(min_fh_tab[ft]), 6'(ft), 6'(2 * ft),
                     1'(ft));
    endtask

    task automatic test_rejects();
        send_req(4'd12, 7'd8, 7'd8, 6'd0, 6'd0, 1'b0);
        send_req(4'd15, 7'd127, 7'd127, 6'd63, 6'd63, 1'b1);
        send_req(FT_CHECKER, 7'd1, 7'd6, 6'd1, 6'd1, 1'b0);
        send_req(FT_LINE4_C, 7'd6, 7'd3, 6'd1, 6'd1, 1'b1);
        send_req(FT_FULL, 7'd65, 7'd4, 6'd0, 6'd0, 1'b0);
        send_req(FT_FULL, 7'd4, 7'd127, 6'd0, 6'd0, 1'b0);
        send_req(FT_FULL, 7'd0, 7'd4, 6'd0, 6'd0, 1'b1);
    endtask

    task automatic test_edges();
        send_req(FT_FULL, 7'd1, 7'd1, 6'd0, 6'd0, 1'b0);
        send_req(FT_FULL, 7'd64, 7'd64, 6'd63, 6'd63, 1'b1);
        // Thin templates leave a zero-width side rectangle.
        send_req(FT_LINE3_S, 7'd2, 7'd3, 6'd5, 6'd5, 1'b0);
        send_req(FT_LINE4_S, 7'd3, 7'd4, 6'd2, 6'd1, 1'b1);
        // Bounding boxes span the default image's height; the first fills it exactly.
        send_req(FT_CENTER, 7'd24, 7'd24, 6'd0, 6'd0, 1'b0);
        send_req(FT_CROSS_B, 7'd24, 7'd9, 6'd0, 6'd0, 1'b1);
    endtask

    task automatic test_image_sizes();
        int sizes[5][2];
        sizes = '{'{1, 1}, '{64, 64}, '{1, 64}, '{64, 1}, '{0, 0}};
        sizes[4][0] = $urandom_range(1, 64);
        sizes[4][1] = $urandom_range(1, 64);
        for (int s = 0; s < 5; s++) begin
            set_image_size(sizes[s][0], sizes[s][1]);
            send_req(FT_FULL, 7'd1, 7'd1, 6'd0, 6'd0, 1'b0);
            repeat (11) send_random_req();
        end
        set_image_size(int'(IMG_W_RST), int'(IMG_H_RST));
    endtask

    task automatic test_random();
        for (int i = 0; i < 260; i++) begin
            // Cycle through both sides idling, one side only and no idling at all.
            src_idle_en = ((i / 50) % 4) inside {0, 1};
            snk_idle_en = ((i / 50) % 4) inside {0, 2};
            send_random_req();
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_for_rects();
        src_idle_en = 1'b0;
        sink_hold_cycles = 120;
        repeat (40) send_random_req();
        src_idle_en = 1'b1;
        wait_for_rects();
    endtask

    task automatic test_drain_pause();
        repeat (5) begin
            repeat (5) send_random_req();
            wait_for_rects();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_templates();
        test_rejects();
        test_edges();
        test_image_sizes();
        test_random();
        test_backpressure();
        test_drain_pause();
        wait_for_rects();
        $display("Covered %0d requests over all templates, rejects and %0d image sizes;",
                 n_requests, n_cfg);
        $display("%0d rectangle beats checked under random stalls and a long sink hold.",
                 n_rects);
        if (fail_count == 0)
            $display("PASS haar_feature_rectangle_generator_core");
        else
            $display("FAIL haar_feature_rectangle_generator_core");
        $finish;
    end

endmodule

### haar_feature_rectangle_generator_core.f
design/hfrg_pkg.sv
design/hfrg_pipe.sv
design/haar_feature_rectangle_generator_core.sv
dv/haar_feature_rectangle_generator_core_tb.sv
